// File: rtl/ppstep_pkg.sv
// Shared types and constants of the proportional pose step block.
package ppstep_pkg;

	// Q3.13 angle constants, wide enough for the raw heading difference
	localparam logic signed [17:0] PI_Q13     = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

	// Configuration register indexes
	localparam logic [2:0] REG_POS_GAIN   = 3'd0;
	localparam logic [2:0] REG_HEAD_GAIN  = 3'd1;
	localparam logic [2:0] REG_SPEED_LIM  = 3'd2;
	localparam logic [2:0] REG_TURN_LIM   = 3'd3;
	localparam logic [2:0] REG_FRAME_PER  = 3'd4;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 31;

	// Iteration counts of the square root and divide pipelines
	localparam int unsigned SQ_STEPS  = 32;
	localparam int unsigned DIV_STEPS = 31;
	localparam int unsigned LONG_LAT  = SQ_STEPS + DIV_STEPS;

	// Per-item data that rides alongside the root and divide pipelines
	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic signed [15:0] h0;
		logic [30:0]        ax;
		logic [30:0]        ay;
		logic               x_neg;
		logic               y_neg;
		logic [25:0]        turn_mag;
		logic               turn_neg;
		logic               over;
	} side_t;

endpackage

// File: rtl/ppstep_if.sv
// Pose input and command output channel interfaces.
interface ppstep_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [15:0] start_heading;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [15:0] target_heading;

	modport source (output valid, start_x, start_y, start_heading, target_x, target_y,
		target_heading, input ready);
	modport sink (input valid, start_x, start_y, start_heading, target_x, target_y,
		target_heading, output ready);
endinterface

interface ppstep_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] next_x;
	logic signed [31:0] next_y;
	logic signed [15:0] next_heading;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] turn_rate;

	modport source (output valid, next_x, next_y, next_heading, vel_x, vel_y, turn_rate,
		input ready);
	modport sink (input valid, next_x, next_y, next_heading, vel_x, vel_y, turn_rate,
		output ready);
endinterface

// File: rtl/proportional_pose_step.sv
// Top level: proportional pose controller with speed and turn rate limits.
//
//  channel   dir  handshake       payload
//  pose_in   in   valid/ready     start and target pose
//  cmd_out   out  valid/ready     next pose and velocity command
//  cfg       in   cfg_we          cfg_index, cfg_data (write only)
//
// One transaction enters per cycle unless the pipeline holds; stages: 5 front, 32 root,
// 31 divide, 3 back. The root and divide pipelines set the depth.
// arst_n clears the valid bits and loads register defaults.
// When cmd_out holds a transaction that is not taken, the whole pipeline holds.
module proportional_pose_step
	import ppstep_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ppstep_in_if.sink             pose_in,
	ppstep_out_if.source          cmd_out
);

	// configuration registers
	logic [15:0] pos_gain_q, head_gain_q, frame_per_q;
	logic [30:0] speed_lim_q, turn_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_gain_q  <= 16'd256;
			head_gain_q <= 16'd256;
			speed_lim_q <= 31'd19660800;
			turn_lim_q  <= 31'd327680;
			frame_per_q <= 16'd1092;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POS_GAIN:  pos_gain_q  <= cfg_data[15:0];
				REG_HEAD_GAIN: head_gain_q <= cfg_data[15:0];
				REG_SPEED_LIM: speed_lim_q <= cfg_data;
				REG_TURN_LIM:  turn_lim_q  <= cfg_data;
				REG_FRAME_PER: frame_per_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [LONG_LAT-1:0] v_dl;

	assign adv           = !v_s8 || cmd_out.ready;
	assign pose_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
			v_dl <= '0;
		end else if (adv) begin
			v_s1 <= pose_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_dl <= {v_dl[LONG_LAT-2:0], v_s5};
			v_s6 <= v_dl[LONG_LAT-1];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: position errors and wrapped heading error
	logic signed [32:0] ex, ey;
	logic signed [17:0] d0, d1, d2, d3;

	function automatic logic signed [17:0] wrap_pass(input logic signed [17:0] d);
		if (d < -PI_Q13)
			return d + TWO_PI_Q13;
		else if (d > PI_Q13)
			return d - TWO_PI_Q13;
		else
			return d;
	endfunction

	always_comb begin
		ex = {pose_in.target_x[31], pose_in.target_x} - {pose_in.start_x[31], pose_in.start_x};
		ey = {pose_in.target_y[31], pose_in.target_y} - {pose_in.start_y[31], pose_in.start_y};
		d0 = 18'(pose_in.target_heading) - 18'(pose_in.start_heading);
		d1 = wrap_pass(d0);
		d2 = wrap_pass(d1);
		d3 = wrap_pass(d2);
	end

	logic [32:0]        exm_s1, eym_s1;
	logic               xn_s1, yn_s1, dn_s1;
	logic [14:0]        dm_s1;
	logic signed [31:0] x0_s1, y0_s1;
	logic signed [15:0] h0_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			xn_s1  <= ex[32];
			yn_s1  <= ey[32];
			exm_s1 <= ex[32] ? 33'(-ex) : 33'(ex);
			eym_s1 <= ey[32] ? 33'(-ey) : 33'(ey);
			dn_s1  <= d3[17];
			dm_s1  <= d3[17] ? 15'(-d3) : 15'(d3);
			x0_s1  <= pose_in.start_x;
			y0_s1  <= pose_in.start_y;
			h0_s1  <= pose_in.start_heading;
		end
	end

	// stage 2: gain products
	logic [48:0] px_full, py_full;
	logic [30:0] pt_full;
	assign px_full = exm_s1 * pos_gain_q;
	assign py_full = eym_s1 * pos_gain_q;
	assign pt_full = dm_s1 * head_gain_q;

	logic [39:0]        mx_s2, my_s2;
	logic [25:0]        tm_s2;
	logic               xn_s2, yn_s2, dn_s2;
	logic signed [31:0] x0_s2, y0_s2;
	logic signed [15:0] h0_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s2 <= px_full[47:8];
			my_s2 <= py_full[47:8];
			tm_s2 <= pt_full[30:5];
			{xn_s2, yn_s2, dn_s2} <= {xn_s1, yn_s1, dn_s1};
			{x0_s2, y0_s2, h0_s2} <= {x0_s1, y0_s1, h0_s1};
		end
	end

	// stage 3: bring both magnitudes under 2^31, clamp the turn rate
	logic [39:0] mor;
	logic [3:0]  shk;

	always_comb begin
		mor = mx_s2 | my_s2;
		shk = '0;
		for (int i = 31; i < 40; i++) begin
			if (mor[i])
				shk = 4'(i - 30);
		end
	end

	logic [30:0]        ax_s3, ay_s3;
	logic               ok_s3;
	logic [25:0]        tm_s3;
	logic               xn_s3, yn_s3, dn_s3;
	logic signed [31:0] x0_s3, y0_s3;
	logic signed [15:0] h0_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s3 <= 31'(mx_s2 >> shk);
			ay_s3 <= 31'(my_s2 >> shk);
			ok_s3 <= (shk != '0);
			tm_s3 <= ({5'd0, tm_s2} > turn_lim_q) ? turn_lim_q[25:0] : tm_s2;
			{xn_s3, yn_s3, dn_s3} <= {xn_s2, yn_s2, dn_s2};
			{x0_s3, y0_s3, h0_s3} <= {x0_s2, y0_s2, h0_s2};
		end
	end

	// stage 4: squares and scaled dividends
	logic [61:0]        sqx_s4, sqy_s4, slsq_s4, nmx_s4, nmy_s4;
	logic [30:0]        ax_s4, ay_s4;
	logic               ok_s4;
	logic [25:0]        tm_s4;
	logic               xn_s4, yn_s4, dn_s4;
	logic signed [31:0] x0_s4, y0_s4;
	logic signed [15:0] h0_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s4  <= ax_s3 * ax_s3;
			sqy_s4  <= ay_s3 * ay_s3;
			slsq_s4 <= speed_lim_q * speed_lim_q;
			nmx_s4  <= ax_s3 * speed_lim_q;
			nmy_s4  <= ay_s3 * speed_lim_q;
			{ax_s4, ay_s4, ok_s4, tm_s4} <= {ax_s3, ay_s3, ok_s3, tm_s3};
			{xn_s4, yn_s4, dn_s4} <= {xn_s3, yn_s3, dn_s3};
			{x0_s4, y0_s4, h0_s4} <= {x0_s3, y0_s3, h0_s3};
		end
	end

	// stage 5: speed squared and limit test
	logic [62:0] sum_s5;
	logic [61:0] nmx_s5, nmy_s5;
	side_t       side_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s5            <= {1'b0, sqx_s4} + {1'b0, sqy_s4};
			nmx_s5            <= nmx_s4;
			nmy_s5            <= nmy_s4;
			side_s5.x0        <= x0_s4;
			side_s5.y0        <= y0_s4;
			side_s5.h0        <= h0_s4;
			side_s5.ax        <= ax_s4;
			side_s5.ay        <= ay_s4;
			side_s5.x_neg     <= xn_s4;
			side_s5.y_neg     <= yn_s4;
			side_s5.turn_mag  <= tm_s4;
			side_s5.turn_neg  <= dn_s4;
			side_s5.over      <= ok_s4 || (({1'b0, sqx_s4} + {1'b0, sqy_s4}) > {1'b0, slsq_s4});
		end
	end

	// side data waits for the root and divide pipelines, the dividends for the root pipeline only
	side_t       side_dl [LONG_LAT];
	logic [61:0] nmx_dl  [SQ_STEPS];
	logic [61:0] nmy_dl  [SQ_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dl[0] <= side_s5;
			for (int i = 1; i < LONG_LAT; i++)
				side_dl[i] <= side_dl[i-1];
			nmx_dl[0] <= nmx_s5;
			nmy_dl[0] <= nmy_s5;
			for (int i = 1; i < SQ_STEPS; i++) begin
				nmx_dl[i] <= nmx_dl[i-1];
				nmy_dl[i] <= nmy_dl[i-1];
			end
		end
	end

	logic [31:0] speed;
	logic [30:0] qx, qy;

	ppstep_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (sum_s5),
		.root (speed)
	);

	ppstep_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (nmx_dl[SQ_STEPS-1]),
		.den (speed),
		.quo (qx)
	);

	ppstep_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (nmy_dl[SQ_STEPS-1]),
		.den (speed),
		.quo (qy)
	);

	// stage 6: pick scaled or raw velocity
	side_t sd;
	assign sd = side_dl[LONG_LAT-1];

	logic [30:0]        vxm_s6, vym_s6;
	logic               xn_s6, yn_s6, dn_s6;
	logic [25:0]        tm_s6;
	logic signed [31:0] x0_s6, y0_s6;
	logic signed [15:0] h0_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			vxm_s6 <= sd.over ? qx : sd.ax;
			vym_s6 <= sd.over ? qy : sd.ay;
			{xn_s6, yn_s6, dn_s6} <= {sd.x_neg, sd.y_neg, sd.turn_neg};
			tm_s6 <= sd.turn_mag;
			{x0_s6, y0_s6, h0_s6} <= {sd.x0, sd.y0, sd.h0};
		end
	end

	// stage 7: motion over one frame
	logic [46:0] fx_full, fy_full;
	logic [41:0] fh_full;
	assign fx_full = vxm_s6 * frame_per_q;
	assign fy_full = vym_s6 * frame_per_q;
	assign fh_full = tm_s6 * frame_per_q;

	logic [30:0]        fx_s7, fy_s7, vxm_s7, vym_s7;
	logic [22:0]        fh_s7;
	logic [25:0]        tm_s7;
	logic               xn_s7, yn_s7, dn_s7;
	logic signed [31:0] x0_s7, y0_s7;
	logic signed [15:0] h0_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s7 <= fx_full[46:16];
			fy_s7 <= fy_full[46:16];
			fh_s7 <= fh_full[41:19];
			{vxm_s7, vym_s7, tm_s7} <= {vxm_s6, vym_s6, tm_s6};
			{xn_s7, yn_s7, dn_s7} <= {xn_s6, yn_s6, dn_s6};
			{x0_s7, y0_s7, h0_s7} <= {x0_s6, y0_s6, h0_s6};
		end
	end

	// stage 8: saturating pose update, output register
	logic signed [32:0] sx, sy;
	logic signed [24:0] sh;
	logic signed [31:0] nx, ny;
	logic signed [15:0] nh;

	always_comb begin
		sx = 33'(x0_s7) + (xn_s7 ? -$signed({2'b00, fx_s7}) : $signed({2'b00, fx_s7}));
		sy = 33'(y0_s7) + (yn_s7 ? -$signed({2'b00, fy_s7}) : $signed({2'b00, fy_s7}));
		sh = 25'(h0_s7) + (dn_s7 ? -$signed({2'b00, fh_s7}) : $signed({2'b00, fh_s7}));
		if (sx[32] != sx[31])
			nx = sx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			nx = sx[31:0];
		if (sy[32] != sy[31])
			ny = sy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			ny = sy[31:0];
		if (sh > 25'sd32767)
			nh = 16'sh7FFF;
		else if (sh < -25'sd32768)
			nh = 16'sh8000;
		else
			nh = sh[15:0];
	end

	logic signed [31:0] nx_s8, ny_s8, vx_s8, vy_s8, tr_s8;
	logic signed [15:0] nh_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s8 <= nx;
			ny_s8 <= ny;
			nh_s8 <= nh;
			vx_s8 <= xn_s7 ? -$signed({1'b0, vxm_s7}) : $signed({1'b0, vxm_s7});
			vy_s8 <= yn_s7 ? -$signed({1'b0, vym_s7}) : $signed({1'b0, vym_s7});
			tr_s8 <= dn_s7 ? -$signed({6'd0, tm_s7}) : $signed({6'd0, tm_s7});
		end
	end

	assign cmd_out.valid        = v_s8;
	assign cmd_out.next_x       = nx_s8;
	assign cmd_out.next_y       = ny_s8;
	assign cmd_out.next_heading = nh_s8;
	assign cmd_out.vel_x        = vx_s8;
	assign cmd_out.vel_y        = vy_s8;
	assign cmd_out.turn_rate    = tr_s8;

endmodule

// File: rtl/ppstep_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module ppstep_sqrt
	import ppstep_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [62:0] rad,
	output logic [31:0] root
);

	logic [32:0] rem_s  [SQ_STEPS];
	logic [31:0] root_s [SQ_STEPS];
	logic [63:0] rad_s  [SQ_STEPS];

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
		localparam int unsigned P = 2 * (SQ_STEPS - 1 - i);
		logic [32:0] rem_in;
		logic [31:0] root_in;
		logic [63:0] rad_in;
		logic [34:0] cand;
		logic [34:0] trial;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = {1'b0, rad};
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign rad_in  = rad_s[i-1];
		end

		// bring down the next bit pair and try the odd step
		assign cand  = {rem_in, rad_in[P+1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i] <= rad_in;
				if (cand >= trial) begin
					rem_s[i]  <= 33'(cand - trial);
					root_s[i] <= {root_in[30:0], 1'b1};
				end else begin
					rem_s[i]  <= cand[32:0];
					root_s[i] <= {root_in[30:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[SQ_STEPS-1];

endmodule

// File: rtl/ppstep_div.sv
// Pipelined restoring divider, one quotient bit per stage; zero divisor gives zero.
module ppstep_div
	import ppstep_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] num,
	input  logic [31:0] den,
	output logic [30:0] quo
);

	logic [31:0] rem_s [DIV_STEPS];
	logic [30:0] q_s   [DIV_STEPS];
	logic [61:0] num_s [DIV_STEPS];
	logic [31:0] den_s [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int unsigned B = DIV_STEPS - 1 - j;
		logic [31:0] rem_in;
		logic [30:0] q_in;
		logic [61:0] num_in;
		logic [31:0] den_in;
		logic [32:0] cand;

		// the quotient fits in 31 bits, so the upper dividend bits start as remainder
		if (j == 0) begin : g_first
			assign rem_in = {1'b0, num[61:31]};
			assign q_in   = '0;
			assign num_in = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign q_in   = q_s[j-1];
			assign num_in = num_s[j-1];
			assign den_in = den_s[j-1];
		end

		assign cand = {rem_in, num_in[B]};

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[j] <= num_in;
				den_s[j] <= den_in;
				if (cand >= {1'b0, den_in}) begin
					rem_s[j] <= 32'(cand - {1'b0, den_in});
					q_s[j]   <= {q_in[29:0], 1'b1};
				end else begin
					rem_s[j] <= cand[31:0];
					q_s[j]   <= {q_in[29:0], 1'b0};
				end
			end
		end
	end

	assign quo = (den_s[DIV_STEPS-1] == '0) ? '0 : q_s[DIV_STEPS-1];

endmodule
